FILE: rtl/plss_pkg.sv
`timescale 1ns / 1ps
// plss_pkg: shared types, constants and the CORDIC step-angle table for the
// projectile launch speed solver. No dependencies.
package plss_pkg;

	localparam int COORD_BITS        = 16;
	localparam int DX_BITS           = COORD_BITS + 1;
	localparam int ANGLE_BITS        = 14;
	localparam int SPEED_BITS        = 16;
	localparam int TIME_BITS         = 24;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int CW                = 34;   // CORDIC datapath width

	localparam logic [ANGLE_BITS-1:0] ANGLE_MIN   = 14'd1;
	localparam logic [ANGLE_BITS-1:0] ANGLE_MAX   = 14'd8999;
	localparam logic [ANGLE_BITS-1:0] ANGLE_RESET = 14'd4500;

	localparam logic [17:0] CDEG_TO_Q30 = 18'd187403;    // 0.01 deg -> rad, Q30
	localparam logic [29:0] GAIN_Q30    = 30'd652032874; // 1/K, Q30
	localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
	localparam logic [29:0] G_Q16       = 30'd642688614; // 9806.65 mm/s^2, Q16
	localparam logic [39:0] US2_PER_S2  = 40'd1000000000000;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] target_x;
		logic signed [COORD_BITS-1:0] target_y;
	} req_t;

	typedef struct packed {
		logic [SPEED_BITS-1:0] launch_speed;
		logic [TIME_BITS-1:0]  flight_time;
		logic                  no_solution;
	} res_t;

	// atan(2^-i) in Q30; 2^(30-i) once the small-angle form is exact enough
	function automatic logic signed [CW-1:0] step_angle(input int i);
		logic signed [CW-1:0] r;
		r = '0;
		case (i)
			0: r = CW'(32'h3243F6A8);
			1: r = CW'(32'h1DAC6705);
			2: r = CW'(32'h0FADBAFC);
			3: r = CW'(32'h07F56EA6);
			4: r = CW'(32'h03FEAB76);
			5: r = CW'(32'h01FFD55B);
			6: r = CW'(32'h00FFFAAA);
			7: r = CW'(32'h007FFF55);
			8: r = CW'(32'h003FFFEA);
			9: r = CW'(32'h001FFFFD);
			default: begin
				if (i <= 30) r = CW'(1) << (30 - i);
				else r = '0;
			end
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/projectile_launch_speed_solver.sv
`timescale 1ns / 1ps
// projectile_launch_speed_solver: launch speed and flight time for a target.
// Throughput: one request per cycle; the whole chain advances together and
// holds only while the output register is full and not taken.
// Reset (arst_n low): all stage valids clear, the angle register angle_q returns to 4500.
// Depends on plss_pkg, plss_cordic_cell, plss_mul2, plss_div_cell, plss_sqrt_cell.
module projectile_launch_speed_solver #(
	parameter int CORDIC_STAGES = plss_pkg::CORDIC_STAGES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [plss_pkg::ANGLE_BITS-1:0]   cfg_data,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  plss_pkg::req_t                    req_data,
	output logic                              res_valid,
	input  logic                              res_ready,
	output plss_pkg::res_t                    res_data
);

	localparam int UW   = plss_pkg::COORD_BITS;
	localparam int DXW  = plss_pkg::DX_BITS;
	localparam int CW   = plss_pkg::CW;
	localparam int PW   = 32 + DXW;        // s*dx, c*dy
	localparam int BW   = PW + 1;          // bracket, signed
	localparam int BUW  = BW - 1;          // bracket magnitude
	localparam int NW1  = 30 + 2 * UW;     // g*dx^2
	localparam int DW1  = 32 + BUW;        // 2*c*B
	localparam int QB1  = 32;
	localparam int RW1A = NW1 + 44;
	localparam int RW1B = DW1 + QB1 + 1;
	localparam int RW1  = (RW1A > RW1B) ? RW1A : RW1B;
	localparam int NW2  = 40 + BUW;        // B*1e12
	localparam int DW2  = 61;              // g*c
	localparam int QB2  = 48;
	localparam int RW2A = NW2 + 17;
	localparam int RW2B = DW2 + QB2 + 1;
	localparam int RW2  = (RW2A > RW2B) ? RW2A : RW2B;
	localparam int SR1  = 16;              // speed root bits
	localparam int SR2  = 24;              // time root bits
	localparam int SWC  = 2 * DXW;
	localparam int SWD1 = 1 + NW2 + DW2;
	localparam int SWD2 = 2 + QB1;
	localparam int SWR1 = 3 + QB2;
	localparam int SWR2 = 3 + SR1;

	localparam logic signed [CW-1:0] ONE_C = CW'(plss_pkg::ONE_Q30);

	// ---------------- handshake / config ----------------
	logic en;
	logic res_valid_q;
	plss_pkg::res_t res_q;
	logic [plss_pkg::ANGLE_BITS-1:0] angle_q;

	// whole chain steps unless a finished result sits unclaimed
	assign en        = !res_valid_q || res_ready;
	assign req_ready = en;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) angle_q <= plss_pkg::ANGLE_RESET;
		else if (cfg_we) angle_q <= cfg_data;
	end

	// ---------------- stage 1: deltas and angle in Q30 ----------------
	logic [plss_pkg::ANGLE_BITS-1:0] ang_c;
	logic [31:0] z_prod;
	logic signed [DXW-1:0] dx_n, dy_n;
	logic v_s1;
	logic signed [DXW-1:0] dx_s1, dy_s1;
	logic signed [CW-1:0] z_s1;

	always_comb begin
		if (angle_q < plss_pkg::ANGLE_MIN) ang_c = plss_pkg::ANGLE_MIN;
		else if (angle_q > plss_pkg::ANGLE_MAX) ang_c = plss_pkg::ANGLE_MAX;
		else ang_c = angle_q;
		z_prod = {18'b0, ang_c} * {14'b0, plss_pkg::CDEG_TO_Q30};
		dx_n = {req_data.target_x[UW-1], req_data.target_x}
			- {req_data.start_x[UW-1], req_data.start_x};
		dy_n = {req_data.start_y[UW-1], req_data.start_y}
			- {req_data.target_y[UW-1], req_data.target_y};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= req_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= dx_n;
			dy_s1 <= dy_n;
			z_s1  <= CW'(z_prod);
		end
	end

	// ---------------- CORDIC cell chain: sin/cos ----------------
	logic                 cv    [0:CORDIC_STAGES];
	logic signed [CW-1:0] cx    [0:CORDIC_STAGES];
	logic signed [CW-1:0] cy    [0:CORDIC_STAGES];
	logic signed [CW-1:0] cz    [0:CORDIC_STAGES];
	logic [SWC-1:0]       cside [0:CORDIC_STAGES];

	assign cv[0]    = v_s1;
	assign cx[0]    = CW'(plss_pkg::GAIN_Q30);
	assign cy[0]    = '0;
	assign cz[0]    = z_s1;
	assign cside[0] = {dx_s1, dy_s1};

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		plss_cordic_cell #(.STAGE(i), .SW(SWC)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.prev_valid (cv[i]),
			.prev_x     (cx[i]),
			.prev_y     (cy[i]),
			.prev_z     (cz[i]),
			.prev_side  (cside[i]),
			.next_valid (cv[i+1]),
			.next_x     (cx[i+1]),
			.next_y     (cy[i+1]),
			.next_z     (cz[i+1]),
			.next_side  (cside[i+1])
		);
	end

	// ---------------- stage 2: clamp, early no-solution ----------------
	logic signed [CW-1:0]  xf, yf;
	logic signed [DXW-1:0] dx_c, dy_c;
	logic v_s2, bad_s2;
	logic [30:0] c_s2, s_s2;
	logic signed [DXW-1:0] dx_s2, dy_s2;

	assign xf = cx[CORDIC_STAGES];
	assign yf = cy[CORDIC_STAGES];
	assign {dx_c, dy_c} = cside[CORDIC_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= cv[CORDIC_STAGES];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s2   <= (xf > ONE_C) ? plss_pkg::ONE_Q30 : xf[30:0];
			s_s2   <= (yf > ONE_C) ? plss_pkg::ONE_Q30 : (yf[CW-1] ? 31'd0 : yf[30:0]);
			// target not ahead of launch (dx not positive), or cosine not positive
			bad_s2 <= (dx_c <= 0) || (xf <= 0);
			dx_s2  <= dx_c;
			dy_s2  <= dy_c;
		end
	end

	// ---------------- stage 3: s*dx, c*dy, dx^2 ----------------
	logic v_s3, bad_s3;
	logic signed [PW-1:0] p1_s3, p2_s3;
	logic [2*UW-1:0] dx2_s3;
	logic [30:0] c_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s3  <= $signed({1'b0, s_s2}) * dx_s2;
			p2_s3  <= $signed({1'b0, c_s2}) * dy_s2;
			dx2_s3 <= dx_s2[UW-1:0] * dx_s2[UW-1:0];
			c_s3   <= c_s2;
			bad_s3 <= bad_s2;
		end
	end

	// ---------------- stage 4: bracket B = s*dx + c*dy ----------------
	logic signed [BW-1:0] b_n;
	logic v_s4, bad_s4;
	logic [BUW-1:0] bu_s4;
	logic [2*UW-1:0] dx2_s4;
	logic [30:0] c_s4;

	assign b_n = {p1_s3[PW-1], p1_s3} + {p2_s3[PW-1], p2_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bu_s4  <= b_n[BUW-1:0];
			dx2_s4 <= dx2_s3;
			c_s4   <= c_s3;
			// bracket not positive: apex never reaches the target line
			bad_s4 <= bad_s3 || b_n[BW-1] || (b_n == '0);
		end
	end

	// ---------------- stages 5-6: wide products ----------------
	logic [NW1-1:0]   n1;
	logic [DW1-2:0]   d1h;
	logic [NW2-1:0]   n2;
	logic [DW2-1:0]   d2;
	logic v_s5, v_s6, bad_s5, bad_s6;

	plss_mul2 #(.AW(30), .BW(2 * UW)) u_mul_n1 (
		.clk (clk), .en (en), .a (plss_pkg::G_Q16), .b (dx2_s4), .p (n1)
	);
	plss_mul2 #(.AW(31), .BW(BUW)) u_mul_d1 (
		.clk (clk), .en (en), .a (c_s4), .b (bu_s4), .p (d1h)
	);
	plss_mul2 #(.AW(40), .BW(BUW)) u_mul_n2 (
		.clk (clk), .en (en), .a (plss_pkg::US2_PER_S2), .b (bu_s4), .p (n2)
	);
	plss_mul2 #(.AW(30), .BW(31)) u_mul_d2 (
		.clk (clk), .en (en), .a (plss_pkg::G_Q16), .b (c_s4), .p (d2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bad_s5 <= bad_s4;
			bad_s6 <= bad_s5;
		end
	end

	// ---------------- divider 1: v0^2 = g*dx^2*2^44 / (2*c*B) ----------------
	logic            d1v    [0:QB1+1];
	logic [RW1-1:0]  d1rem  [0:QB1+1];
	logic [DW1-1:0]  d1den  [0:QB1+1];
	logic [QB1-1:0]  d1quo  [0:QB1+1];
	logic            d1sat  [0:QB1+1];
	logic [SWD1-1:0] d1side [0:QB1+1];

	assign d1v[0]    = v_s6;
	assign d1rem[0]  = RW1'(n1) << 44;
	assign d1den[0]  = {d1h, 1'b0};
	assign d1quo[0]  = '0;
	assign d1sat[0]  = 1'b0;
	assign d1side[0] = {bad_s6, n2, d2};

	// first cell only tests for quotient overflow, then one bit per cell
	for (genvar j = 0; j <= QB1; j++) begin : g_div1
		plss_div_cell #(
			.RW(RW1), .DW(DW1), .QB(QB1), .K((j == 0) ? QB1 : QB1 - j),
			.SAT(j == 0), .SW(SWD1)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.prev_valid (d1v[j]),
			.prev_rem   (d1rem[j]),
			.prev_den   (d1den[j]),
			.prev_quo   (d1quo[j]),
			.prev_sat   (d1sat[j]),
			.prev_side  (d1side[j]),
			.next_valid (d1v[j+1]),
			.next_rem   (d1rem[j+1]),
			.next_den   (d1den[j+1]),
			.next_quo   (d1quo[j+1]),
			.next_sat   (d1sat[j+1]),
			.next_side  (d1side[j+1])
		);
	end

	// ---------------- divider 2: t^2 = B*1e12*2^17 / (g*c) ----------------
	logic            bad_d1;
	logic [NW2-1:0]  n2_d1;
	logic [DW2-1:0]  d2_d1;

	assign {bad_d1, n2_d1, d2_d1} = d1side[QB1+1];

	logic            d2v    [0:QB2+1];
	logic [RW2-1:0]  d2rem  [0:QB2+1];
	logic [DW2-1:0]  d2den  [0:QB2+1];
	logic [QB2-1:0]  d2quo  [0:QB2+1];
	logic            d2sat  [0:QB2+1];
	logic [SWD2-1:0] d2side [0:QB2+1];

	assign d2v[0]    = d1v[QB1+1];
	assign d2rem[0]  = RW2'(n2_d1) << 17;
	assign d2den[0]  = d2_d1;
	assign d2quo[0]  = '0;
	assign d2sat[0]  = 1'b0;
	assign d2side[0] = {bad_d1, d1sat[QB1+1], d1quo[QB1+1]};

	for (genvar j = 0; j <= QB2; j++) begin : g_div2
		plss_div_cell #(
			.RW(RW2), .DW(DW2), .QB(QB2), .K((j == 0) ? QB2 : QB2 - j),
			.SAT(j == 0), .SW(SWD2)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.prev_valid (d2v[j]),
			.prev_rem   (d2rem[j]),
			.prev_den   (d2den[j]),
			.prev_quo   (d2quo[j]),
			.prev_sat   (d2sat[j]),
			.prev_side  (d2side[j]),
			.next_valid (d2v[j+1]),
			.next_rem   (d2rem[j+1]),
			.next_den   (d2den[j+1]),
			.next_quo   (d2quo[j+1]),
			.next_sat   (d2sat[j+1]),
			.next_side  (d2side[j+1])
		);
	end

	// ---------------- root 1: launch speed ----------------
	logic           bad_d2, sat1_d2;
	logic [QB1-1:0] q1_d2;

	assign {bad_d2, sat1_d2, q1_d2} = d2side[QB2+1];

	logic            r1v    [0:SR1];
	logic [2*SR1-1:0] r1rem [0:SR1];
	logic [SR1-1:0]  r1root [0:SR1];
	logic [SWR1-1:0] r1side [0:SR1];

	assign r1v[0]    = d2v[QB2+1];
	assign r1rem[0]  = q1_d2;
	assign r1root[0] = '0;
	assign r1side[0] = {bad_d2, sat1_d2, d2sat[QB2+1], d2quo[QB2+1]};

	for (genvar j = 0; j < SR1; j++) begin : g_root1
		plss_sqrt_cell #(.W(SR1), .K(SR1 - 1 - j), .SW(SWR1)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.prev_valid (r1v[j]),
			.prev_rem   (r1rem[j]),
			.prev_root  (r1root[j]),
			.prev_side  (r1side[j]),
			.next_valid (r1v[j+1]),
			.next_rem   (r1rem[j+1]),
			.next_root  (r1root[j+1]),
			.next_side  (r1side[j+1])
		);
	end

	// ---------------- root 2: flight time ----------------
	logic           bad_r1, sat1_r1, sat2_r1;
	logic [QB2-1:0] q2_r1;

	assign {bad_r1, sat1_r1, sat2_r1, q2_r1} = r1side[SR1];

	logic             r2v    [0:SR2];
	logic [2*SR2-1:0] r2rem  [0:SR2];
	logic [SR2-1:0]   r2root [0:SR2];
	logic [SWR2-1:0]  r2side [0:SR2];

	assign r2v[0]    = r1v[SR1];
	assign r2rem[0]  = q2_r1;
	assign r2root[0] = '0;
	assign r2side[0] = {bad_r1, sat1_r1, r1root[SR1], sat2_r1};

	for (genvar j = 0; j < SR2; j++) begin : g_root2
		plss_sqrt_cell #(.W(SR2), .K(SR2 - 1 - j), .SW(SWR2)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.prev_valid (r2v[j]),
			.prev_rem   (r2rem[j]),
			.prev_root  (r2root[j]),
			.prev_side  (r2side[j]),
			.next_valid (r2v[j+1]),
			.next_rem   (r2rem[j+1]),
			.next_root  (r2root[j+1]),
			.next_side  (r2side[j+1])
		);
	end

	// ---------------- output register ----------------
	logic           bad_f, sat1_f, sat2_f;
	logic [SR1-1:0] speed_f;

	assign {bad_f, sat1_f, speed_f, sat2_f} = r2side[SR2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid_q <= 1'b0;
		else if (en) res_valid_q <= r2v[SR2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.no_solution  <= bad_f;
			res_q.launch_speed <= bad_f ? '0 : (sat1_f ? '1 : speed_f);
			res_q.flight_time  <= bad_f ? '0 : (sat2_f ? '1 : r2root[SR2]);
		end
	end

`ifndef SYNTHESIS
	a_nosol_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.no_solution |->
			res_data.launch_speed == '0 && res_data.flight_time == '0)
		else $error("no_solution result carries nonzero fields");

	a_cos_pos: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !bad_s2 |-> c_s2 != '0)
		else $error("zero cosine passed as solvable");

	a_dx_flag: assert property (@(posedge clk) disable iff (!arst_n)
		en && cv[CORDIC_STAGES] && (dx_c <= 0) |=> bad_s2)
		else $error("non-positive dx not flagged");
`endif

endmodule

FILE: rtl/plss_cordic_cell.sv
`timescale 1ns / 1ps
// plss_cordic_cell: one rotation-mode CORDIC micro-rotation, registered.
// Depends on plss_pkg.
module plss_cordic_cell #(
	parameter int STAGE = 0,
	parameter int SW    = 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            prev_valid,
	input  logic signed [plss_pkg::CW-1:0]  prev_x,
	input  logic signed [plss_pkg::CW-1:0]  prev_y,
	input  logic signed [plss_pkg::CW-1:0]  prev_z,
	input  logic [SW-1:0]                   prev_side,
	output logic                            next_valid,
	output logic signed [plss_pkg::CW-1:0]  next_x,
	output logic signed [plss_pkg::CW-1:0]  next_y,
	output logic signed [plss_pkg::CW-1:0]  next_z,
	output logic [SW-1:0]                   next_side
);

	localparam logic signed [plss_pkg::CW-1:0] ANG = plss_pkg::step_angle(STAGE);

	logic signed [plss_pkg::CW-1:0] xs, ys, x_n, y_n, z_n;
	logic signed [plss_pkg::CW-1:0] x_s1, y_s1, z_s1;
	logic [SW-1:0] side_s1;
	logic valid_s1;

	always_comb begin
		xs = prev_x >>> STAGE;
		ys = prev_y >>> STAGE;
		if (!prev_z[plss_pkg::CW-1]) begin
			x_n = prev_x - ys;
			y_n = prev_y + xs;
			z_n = prev_z - ANG;
		end else begin
			x_n = prev_x + ys;
			y_n = prev_y - xs;
			z_n = prev_z + ANG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (en) valid_s1 <= prev_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= x_n;
			y_s1    <= y_n;
			z_s1    <= z_n;
			side_s1 <= prev_side;
		end
	end

	assign next_valid = valid_s1;
	assign next_x     = x_s1;
	assign next_y     = y_s1;
	assign next_z     = z_s1;
	assign next_side  = side_s1;

endmodule

FILE: rtl/plss_mul2.sv
`timescale 1ns / 1ps
// plss_mul2: two-stage unsigned multiplier; a b wider than 32 bits is split
// into its low 32 bits and the rest, partial products then sum. Depends on nothing.
module plss_mul2 #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  logic             clk,
	input  logic             en,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic [AW+BW-1:0] p
);

	logic [AW+BW-1:0] p_s2;

	if (BW > 32) begin : g_split
		localparam int HW = BW - 32;
		logic [AW+31:0]   lo_s1;
		logic [AW+HW-1:0] hi_s1;
		always_ff @(posedge clk) begin
			if (en) begin
				lo_s1 <= a * b[31:0];
				hi_s1 <= a * b[BW-1:32];
				p_s2  <= (AW+BW)'(lo_s1) + ((AW+BW)'(hi_s1) << 32);
			end
		end
	end else begin : g_one
		logic [AW+BW-1:0] p_s1;
		always_ff @(posedge clk) begin
			if (en) begin
				p_s1 <= a * b;
				p_s2 <= p_s1;
			end
		end
	end

	assign p = p_s2;

endmodule

FILE: rtl/plss_div_cell.sv
`timescale 1ns / 1ps
// plss_div_cell: one restoring long-division step (or the overflow test
// when SAT is set), registered. Depends on nothing.
module plss_div_cell #(
	parameter int RW  = 64,
	parameter int DW  = 32,
	parameter int QB  = 32,
	parameter int K   = 0,
	parameter bit SAT = 1'b0,
	parameter int SW  = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          prev_valid,
	input  logic [RW-1:0] prev_rem,
	input  logic [DW-1:0] prev_den,
	input  logic [QB-1:0] prev_quo,
	input  logic          prev_sat,
	input  logic [SW-1:0] prev_side,
	output logic          next_valid,
	output logic [RW-1:0] next_rem,
	output logic [DW-1:0] next_den,
	output logic [QB-1:0] next_quo,
	output logic          next_sat,
	output logic [SW-1:0] next_side
);

	logic [RW-1:0] dsh, rem_n;
	logic [QB-1:0] quo_n;
	logic ge, sat_n;
	logic valid_s1, sat_s1;
	logic [RW-1:0] rem_s1;
	logic [DW-1:0] den_s1;
	logic [QB-1:0] quo_s1;
	logic [SW-1:0] side_s1;

	always_comb begin
		dsh   = RW'(prev_den) << K;
		ge    = prev_rem >= dsh;
		rem_n = prev_rem;
		quo_n = prev_quo;
		sat_n = prev_sat;
		if (SAT) begin
			sat_n = prev_sat | ge;
		end else if (ge) begin
			rem_n = prev_rem - dsh;
			quo_n = prev_quo | (QB'(1) << K);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (en) valid_s1 <= prev_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1  <= rem_n;
			den_s1  <= prev_den;
			quo_s1  <= quo_n;
			sat_s1  <= sat_n;
			side_s1 <= prev_side;
		end
	end

	assign next_valid = valid_s1;
	assign next_rem   = rem_s1;
	assign next_den   = den_s1;
	assign next_quo   = quo_s1;
	assign next_sat   = sat_s1;
	assign next_side  = side_s1;

endmodule

FILE: rtl/plss_sqrt_cell.sv
`timescale 1ns / 1ps
// plss_sqrt_cell: one digit-by-digit integer square root step for root
// bit K, registered. Depends on nothing.
module plss_sqrt_cell #(
	parameter int W  = 16,
	parameter int K  = 0,
	parameter int SW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           prev_valid,
	input  logic [2*W-1:0] prev_rem,
	input  logic [W-1:0]   prev_root,
	input  logic [SW-1:0]  prev_side,
	output logic           next_valid,
	output logic [2*W-1:0] next_rem,
	output logic [W-1:0]   next_root,
	output logic [SW-1:0]  next_side
);

	localparam int TW = 2 * W + 1;

	logic [TW-1:0] t;
	logic ge;
	logic [2*W-1:0] rem_n, rem_s1;
	logic [W-1:0] root_n, root_s1;
	logic [SW-1:0] side_s1;
	logic valid_s1;

	// (root + 2^K)^2 - root^2, root holding only bits above K
	always_comb begin
		t      = (TW'(prev_root) << (K + 1)) | (TW'(1) << (2 * K));
		ge     = {1'b0, prev_rem} >= t;
		rem_n  = ge ? (prev_rem - t[2*W-1:0]) : prev_rem;
		root_n = ge ? (prev_root | (W'(1) << K)) : prev_root;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (en) valid_s1 <= prev_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1  <= rem_n;
			root_s1 <= root_n;
			side_s1 <= prev_side;
		end
	end

	assign next_valid = valid_s1;
	assign next_rem   = rem_s1;
	assign next_root  = root_s1;
	assign next_side  = side_s1;

endmodule

FILE: bench/plss_checker.sv
`timescale 1ns / 1ps
// plss_checker: watches the request, result and configuration ports of the launch speed
// solver, predicts each result and compares it with what comes out. Depends on plss_pkg.
module plss_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [13:0]    cfg_data,
	input  logic           req_valid,
	input  logic           req_ready,
	input  plss_pkg::req_t req_data,
	input  logic           res_valid,
	input  logic           res_ready,
	input  plss_pkg::res_t res_data,
	output int             errors,
	output int             pending
);

	localparam longint ATAN_Q30 [10] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
		64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD
	};
	localparam longint Q30_ONE = 64'h4000_0000;
	localparam longint GRAV_Q16 = 642688614;

	logic [13:0]    angle_reg;
	plss_pkg::res_t solutions[$];

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic plss_pkg::res_t solve_launch(input plss_pkg::req_t r,
		input logic [13:0] ang_in);
		longint            ang, x, y, z, xs, ys, rot, c, s, dx, dy, brk;
		logic [191:0]      num, den, quo;
		plss_pkg::res_t    o;
		ang = ang_in;
		if (ang < 1) ang = 1;
		if (ang > 8999) ang = 8999;
		x = 652032874;
		y = 0;
		z = ang * 187403;
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;   // floor shift on signed
			ys = y >>> i;
			rot = (i < 10) ? ATAN_Q30[i] : (64'sd1 <<< (30 - i));
			if (z >= 0) begin
				x -= ys; y += xs; z -= rot;
			end else begin
				x += ys; y -= xs; z += rot;
			end
		end
		c = (x > Q30_ONE) ? Q30_ONE : x;
		s = (y > Q30_ONE) ? Q30_ONE : ((y < 0) ? 0 : y);
		dx = longint'(r.target_x) - longint'(r.start_x);
		dy = longint'(r.start_y) - longint'(r.target_y);
		o = '{launch_speed: '0, flight_time: '0, no_solution: 1'b1};
		if (dx <= 0 || c <= 0) return o;
		brk = s * dx + c * dy;
		if (brk <= 0) return o;
		num = (192'(GRAV_Q16) * 192'(dx * dx)) << 44;
		den = (192'(c) * 192'(brk)) << 1;
		quo = num / den;
		o.launch_speed = ((quo >> 32) != 0) ? 16'hFFFF : 16'(int_sqrt(quo[63:0]));
		num = (192'(brk) * 192'(64'd1000000000000)) << 17;
		den = 192'(GRAV_Q16) * 192'(c);
		quo = num / den;
		o.flight_time = ((quo >> 48) != 0) ? 24'hFFFFFF : 24'(int_sqrt(quo[63:0]));
		o.no_solution = 1'b0;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		plss_pkg::res_t want;
		if (!arst_n) begin
			angle_reg <= plss_pkg::ANGLE_RESET;
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_we) angle_reg <= cfg_data;
			if (req_valid && req_ready) solutions.push_back(solve_launch(req_data, angle_reg));
			if (res_valid && res_ready) begin
				if (solutions.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result %p", res_data);
				end else begin
					want = solutions.pop_front();
					if (want.launch_speed !== res_data.launch_speed ||
					    want.flight_time !== res_data.flight_time ||
					    want.no_solution !== res_data.no_solution) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected spd %0d t %0d ns %0d, got spd %0d t %0d ns %0d",
								want.launch_speed, want.flight_time, want.no_solution,
								res_data.launch_speed, res_data.flight_time,
								res_data.no_solution);
					end
				end
			end
			pending = solutions.size();
		end
	end

endmodule

FILE: bench/projectile_launch_speed_solver_tb.sv
`timescale 1ns / 1ps
// projectile_launch_speed_solver_tb: drives requests and angle settings into the solver
// and gives the verdict. Depends on plss_pkg, plss_checker and the solver RTL.
module projectile_launch_speed_solver_tb;

	localparam int LATENCY   = 145;
	localparam int IDLE_MAX  = 3000;  // cycles without any handshake before giving up
	localparam int LONG_HOLD = 400;   // receiver stall long enough to fill the pipe

	logic           clk = 0;
	logic           arst_n = 0;
	logic           cfg_we = 0;
	logic [13:0]    cfg_data = '0;
	logic           req_valid = 0;
	logic           req_ready;
	plss_pkg::req_t req_data = '0;
	logic           res_valid;
	logic           res_ready = 0;
	plss_pkg::res_t res_data;
	int             errors, pending;
	bit             hold_off = 0;  // asks the receiver for one long stall
	bit             quiet = 0;     // no idling on either side while set
	int             idle_cycles = 0;

	always #5 clk = ~clk;

	projectile_launch_speed_solver DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
		.res_valid(res_valid), .res_ready(res_ready), .res_data(res_data)
	);

	plss_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
		.res_valid(res_valid), .res_ready(res_ready), .res_data(res_data),
		.errors(errors), .pending(pending)
	);

	// watchdog: any handshake resets the count
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (res_valid && res_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_MAX) begin
			$display("projectile_launch_speed_solver regression: fail");
			$finish;
		end
	end

	// result side: random stall per result, one long stall on request
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				hold_off = 0;
				res_ready <= 0;
				repeat (LONG_HOLD) @(negedge clk);
			end
			w = quiet ? 0 : $urandom_range(0, 11);
			if (w > 0) begin
				res_ready <= 0;
				repeat (w) @(negedge clk);
			end
			res_ready <= 1;
			do @(posedge clk); while (!(res_valid && res_ready));
		end
	end

	// called at a falling edge; returns at the falling edge after the request is taken
	task automatic send_request(input plss_pkg::req_t r);
		int w;
		w = quiet ? 0 : $urandom_range(0, 11);
		if (w > 0) begin
			req_valid <= 0;
			repeat (w) @(negedge clk);
		end
		req_valid <= 1;
		req_data  <= r;
		do @(posedge clk); while (!(req_valid && req_ready));
		@(negedge clk);
	endtask

	// angle writes only with the pipe drained
	task automatic set_angle(input logic [13:0] a);
		req_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		cfg_we   <= 1;
		cfg_data <= a;
		@(negedge clk);
		cfg_we <= 0;
		@(negedge clk);
	endtask

	function automatic plss_pkg::req_t pick_request();
		plss_pkg::req_t r;
		int             kind;
		kind = $urandom_range(0, 9);
		r = plss_pkg::req_t'({$urandom, $urandom});
		if (kind <= 6) begin
			// well-formed shot: target ahead, heights close by
			r.start_x  = 16'($signed($urandom_range(0, 32768)) - 32768);
			r.target_x = r.start_x + 16'($urandom_range(1, 32767));
			r.target_y = r.start_y + 16'($signed($urandom_range(0, 8000)) - 4000);
			if (kind == 6) r.target_x = r.start_x + 16'($urandom_range(1, 40));
		end else if (kind == 9) begin
			r.target_x = r.start_x - 16'($urandom_range(0, 32767));  // not ahead unless the subtraction wraps
		end
		return r;
	endfunction

	initial begin
		logic [13:0]    angles[9];
		plss_pkg::req_t r;
		angles = '{14'd4500, 14'd1, 14'd8999, 14'd0, 14'd16383, 14'd3000, 14'd6000,
		           14'd100, 14'd8000};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed shots under the reset angle
		send_request('{start_x: 0, start_y: 0, target_x: 1000, target_y: 0});
		send_request('{start_x: 0, start_y: 0, target_x: 0, target_y: 0});       // dx zero
		send_request('{start_x: 500, start_y: 0, target_x: -500, target_y: 0});   // behind
		send_request('{start_x: -32768, start_y: 32767, target_x: 32767, target_y: -32768});
		send_request('{start_x: -32768, start_y: -32768, target_x: 32767, target_y: 32767});
		send_request('{start_x: 32767, start_y: 0, target_x: -32768, target_y: 0});
		send_request('{start_x: 0, start_y: -32768, target_x: 1, target_y: 32767}); // unreachable
		send_request('{start_x: 0, start_y: 32767, target_x: 1, target_y: -32768});
		send_request('{start_x: 0, start_y: 0, target_x: 1, target_y: 0});
		send_request('{start_x: 0, start_y: 0, target_x: 32767, target_y: 0});
		send_request('{start_x: 0, start_y: 0, target_x: 100, target_y: 100});      // bracket zero
		send_request('{start_x: -1, start_y: -1, target_x: 0, target_y: 0});

		for (int p = 0; p < 9; p++) begin
			set_angle(angles[p]);
			if (p == 0) begin
				// near-flat shot: speed saturates; dy positive keeps the bracket above zero
				set_angle(14'd1);
				send_request('{start_x: 0, start_y: 0, target_x: 32767, target_y: 0});
				send_request('{start_x: 0, start_y: 32767, target_x: 32767, target_y: -32768});
				set_angle(14'd8999);  // near-vertical: flight time saturates
				send_request('{start_x: 0, start_y: 0, target_x: 1, target_y: 0});
				send_request('{start_x: 0, start_y: 32767, target_x: 32767, target_y: -32768});
				set_angle(angles[p]);
			end
			if (p == 1) hold_off = 1;  // sender keeps offering while results back up
			for (int n = 0; n < 56; n++) begin
				if (n % 20 == 0) quiet = ($urandom_range(0, 3) == 0);
				if (p == 3 && n == 28) begin
					req_valid <= 0;
					while (pending != 0) @(negedge clk);
				end
				r = pick_request();
				send_request(r);
			end
			quiet = 0;
		end

		req_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 20) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("projectile_launch_speed_solver regression: pass");
		else
			$display("projectile_launch_speed_solver regression: fail");
		$finish;
	end

endmodule
